// ===== rtl/core/orq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// orq_pkg: shared definitions for the offline range-minimum query block
// Field widths, status codes, operation codes and the structs that travel
// between the sequencer, the stores and the top level.
// ----------------------------------------------------------------------------
package orq_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int VALUE_WIDTH_DEF  = 32;

   localparam int DATA_W      = 32;
   localparam int POS_W       = 10;
   localparam int TAG_W       = 8;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 56;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LEFT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic value_we;
      logic parent_we;
      logic stack_we;
   } store_we_type;

   typedef struct packed {
      logic [DATA_W-1:0]   value;
      logic [POS_W-1:0]    position;
      logic [TAG_W-1:0]    tag;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/core/offline_range_min_query_top.sv =====
`default_nettype none
// Push: each stack entry compared takes one stack read and one value read
//   and compare before the new element is written.
// Query: the parent chain is walked to the root and the path then compressed
//   before the result; error results skip the walk. One transaction at a time.
// Reset: synchronous, clears stack depth, element count and control state;
//   memory contents are not cleared and are only read where written.
// ----------------------------------------------------------------------------
// offline_range_min_query_top: range-minimum query unit
// Monotonic stack plus union-find parent store with path compression; the
// result goes through an output register so the next request is taken while
// a result waits.
// ----------------------------------------------------------------------------
module offline_range_min_query_top #(
   parameter int MAX_ELEMENTS = orq_pkg::MAX_ELEMENTS_DEF,
   parameter int VALUE_WIDTH  = orq_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [31:0] element_value, [41:32] left_index, [49:42] query_tag
   input  wire logic [orq_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] operation
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [31:0] min_value, [41:32] min_position, [49:42] tag_out
   output logic [orq_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   // [1:0] status
   output logic [orq_pkg::STATUS_W-1:0]             rsp_tuser
);

   localparam int IW  = $clog2(MAX_ELEMENTS);
   localparam int CW  = $clog2(MAX_ELEMENTS + 1);
   localparam int SW  = (VALUE_WIDTH < orq_pkg::DATA_W) ? VALUE_WIDTH : orq_pkg::DATA_W;
   localparam int PAD = orq_pkg::RSP_TDATA_W - orq_pkg::DATA_W - orq_pkg::POS_W
                      - orq_pkg::TAG_W;

   orq_pkg::store_we_type we;
   orq_pkg::result_type   res;
   logic                  res_valid;
   logic                  res_ready;

   logic [IW-1:0]        value_waddr, value_raddr;
   logic signed [SW-1:0] value_wdata, value_rdata;
   logic [IW-1:0]        parent_waddr, parent_wdata, parent_raddr, parent_rdata;
   logic [IW-1:0]        stack_waddr, stack_wdata, stack_raddr, stack_rdata;
   logic [CW-1:0]        stack_depth, element_count;

   logic                rsp_valid_ff, rsp_valid_in;
   orq_pkg::result_type rsp_data_ff, rsp_data_in;

   assign res_ready = !rsp_valid_ff || rsp_tready;

   orq_seq #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .IW           (IW),
      .CW           (CW),
      .SW           (SW)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_op        (req_tuser),
      .req_value     (req_tdata[31:0]),
      .req_left      (req_tdata[41:32]),
      .req_tag       (req_tdata[49:42]),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res),
      .we            (we),
      .value_waddr   (value_waddr),
      .value_wdata   (value_wdata),
      .value_raddr   (value_raddr),
      .value_rdata   (value_rdata),
      .parent_waddr  (parent_waddr),
      .parent_wdata  (parent_wdata),
      .parent_raddr  (parent_raddr),
      .parent_rdata  (parent_rdata),
      .stack_waddr   (stack_waddr),
      .stack_wdata   (stack_wdata),
      .stack_raddr   (stack_raddr),
      .stack_rdata   (stack_rdata),
      .stack_depth   (stack_depth),
      .element_count (element_count)
   );

   orq_store #(
      .DEPTH (MAX_ELEMENTS),
      .IW    (IW),
      .SW    (SW)
   ) u_store (
      .clock        (clock),
      .we           (we),
      .value_waddr  (value_waddr),
      .value_wdata  (value_wdata),
      .value_raddr  (value_raddr),
      .value_rdata  (value_rdata),
      .parent_waddr (parent_waddr),
      .parent_wdata (parent_wdata),
      .parent_raddr (parent_raddr),
      .parent_rdata (parent_rdata),
      .stack_waddr  (stack_waddr),
      .stack_wdata  (stack_wdata),
      .stack_raddr  (stack_raddr),
      .stack_rdata  (stack_rdata)
   );

   // output register: load a new result, or drop the one just taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD{1'b0}}, rsp_data_ff.tag, rsp_data_ff.position,
                        rsp_data_ff.value};
   assign rsp_tuser  = rsp_data_ff.status;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a waiting transaction");

   a_depth_le_count: assert property (@(posedge clock) disable iff (reset)
      stack_depth <= element_count)
      else $error("stack deeper than element count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      element_count <= CW'(MAX_ELEMENTS))
      else $error("element count above capacity");

   a_root_in_range: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.status == orq_pkg::STATUS_OK)
         |-> ({{CW{1'b0}}, res.position} < {{orq_pkg::POS_W{1'b0}}, element_count}))
      else $error("answer position beyond pushed elements");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/orq_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// orq_store: element, parent and stack memories
// Three single-port-write, single-port-read memories with registered read
// data. Contents are not cleared by reset.
// ----------------------------------------------------------------------------
module orq_store #(
   parameter int DEPTH = orq_pkg::MAX_ELEMENTS_DEF,
   parameter int IW    = 10,
   parameter int SW    = 32
) (
   input  wire logic                  clock,
   input  wire orq_pkg::store_we_type we,
   input  wire logic [IW-1:0]         value_waddr,
   input  wire logic signed [SW-1:0]  value_wdata,
   input  wire logic [IW-1:0]         value_raddr,
   output logic signed [SW-1:0]       value_rdata,
   input  wire logic [IW-1:0]         parent_waddr,
   input  wire logic [IW-1:0]         parent_wdata,
   input  wire logic [IW-1:0]         parent_raddr,
   output logic [IW-1:0]              parent_rdata,
   input  wire logic [IW-1:0]         stack_waddr,
   input  wire logic [IW-1:0]         stack_wdata,
   input  wire logic [IW-1:0]         stack_raddr,
   output logic [IW-1:0]              stack_rdata
);

   logic signed [SW-1:0] value_mem  [DEPTH];
   logic [IW-1:0]        parent_mem [DEPTH];
   logic [IW-1:0]        stack_mem  [DEPTH];

   always_ff @(posedge clock) begin
      if (we.value_we) begin
         value_mem[value_waddr] <= value_wdata;
      end
      value_rdata <= value_mem[value_raddr];
   end

   always_ff @(posedge clock) begin
      if (we.parent_we) begin
         parent_mem[parent_waddr] <= parent_wdata;
      end
      parent_rdata <= parent_mem[parent_raddr];
   end

   always_ff @(posedge clock) begin
      if (we.stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      stack_rdata <= stack_mem[stack_raddr];
   end

endmodule
`default_nettype wire

// ===== rtl/core/orq_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// orq_seq: push / query sequencer
// Pops the monotonic stack one entry per compare, walks the parent chain to
// the root and compresses the path, all through one value comparator and
// the registered memory read ports.
// ----------------------------------------------------------------------------
module orq_seq #(
   parameter int MAX_ELEMENTS = orq_pkg::MAX_ELEMENTS_DEF,
   parameter int IW           = 10,
   parameter int CW           = 11,
   parameter int SW           = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_op,
   input  wire logic [orq_pkg::DATA_W-1:0]    req_value,
   input  wire logic [orq_pkg::POS_W-1:0]     req_left,
   input  wire logic [orq_pkg::TAG_W-1:0]     req_tag,
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output orq_pkg::result_type                res,
   output orq_pkg::store_we_type              we,
   output logic [IW-1:0]                      value_waddr,
   output logic signed [SW-1:0]               value_wdata,
   output logic [IW-1:0]                      value_raddr,
   input  wire logic signed [SW-1:0]          value_rdata,
   output logic [IW-1:0]                      parent_waddr,
   output logic [IW-1:0]                      parent_wdata,
   output logic [IW-1:0]                      parent_raddr,
   input  wire logic [IW-1:0]                 parent_rdata,
   output logic [IW-1:0]                      stack_waddr,
   output logic [IW-1:0]                      stack_wdata,
   output logic [IW-1:0]                      stack_raddr,
   input  wire logic [IW-1:0]                 stack_rdata,
   output logic [CW-1:0]                      stack_depth,
   output logic [CW-1:0]                      element_count
);

   localparam int DW   = orq_pkg::DATA_W;
   localparam int PW   = orq_pkg::POS_W;
   localparam int CMPW = (CW > PW) ? CW : PW;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_POP_IDX = 3'd1;
   localparam logic [2:0] S_POP_CMP = 3'd2;
   localparam logic [2:0] S_WRITE   = 3'd3;
   localparam logic [2:0] S_FIND    = 3'd4;
   localparam logic [2:0] S_COMP    = 3'd5;
   localparam logic [2:0] S_RESP    = 3'd6;

   logic [2:0]                      state_ff, state_in;
   logic [CW-1:0]                   depth_ff, depth_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic signed [SW-1:0]            vnew_ff, vnew_in;
   logic [orq_pkg::TAG_W-1:0]       tag_ff, tag_in;
   logic [orq_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [IW-1:0]                   left_ff, left_in;
   logic [IW-1:0]                   cur_ff, cur_in;
   logic [IW-1:0]                   root_ff, root_in;
   logic [IW-1:0]                   top_ff, top_in;

   logic [CW-1:0] depth_m1;
   logic [CW-1:0] depth_m2;
   logic [IW-1:0] idx;
   logic [IW-1:0] left_idx;
   logic          bad_left;
   logic          full;
   logic          top_greater;
   logic          at_root;

   assign depth_m1    = depth_ff - CW'(1);
   assign depth_m2    = depth_ff - CW'(2);
   assign idx         = count_ff[IW-1:0];
   assign left_idx    = IW'(req_left);
   assign bad_left    = CMPW'(req_left) >= CMPW'(count_ff);
   assign full        = count_ff == CW'(MAX_ELEMENTS);
   // the shared comparator: stacked value strictly above the new value
   assign top_greater = value_rdata > vnew_ff;
   assign at_root     = parent_rdata == cur_ff;

   assign req_ready     = state_ff == S_IDLE;
   assign stack_depth   = depth_ff;
   assign element_count = count_ff;

   // memory addressing
   always_comb begin
      stack_raddr  = (state_ff == S_IDLE) ? depth_m1[IW-1:0] : depth_m2[IW-1:0];
      value_raddr  = (state_ff == S_POP_IDX) ? stack_rdata
                   : (state_ff == S_FIND) ? cur_ff : root_ff;
      if (state_ff == S_IDLE) begin
         parent_raddr = left_idx;
      end else if (state_ff == S_FIND && at_root) begin
         parent_raddr = left_ff;
      end else begin
         parent_raddr = parent_rdata;
      end
      value_waddr  = idx;
      value_wdata  = vnew_ff;
      stack_waddr  = depth_ff[IW-1:0];
      stack_wdata  = idx;
      parent_waddr = (state_ff == S_POP_CMP) ? top_ff
                   : (state_ff == S_WRITE) ? idx : cur_ff;
      parent_wdata = (state_ff == S_COMP) ? root_ff : idx;
   end

   always_comb begin
      state_in  = state_ff;
      depth_in  = depth_ff;
      count_in  = count_ff;
      vnew_in   = vnew_ff;
      tag_in    = tag_ff;
      status_in = status_ff;
      left_in   = left_ff;
      cur_in    = cur_ff;
      root_in   = root_ff;
      top_in    = top_ff;
      we        = '0;
      res_valid = 1'b0;
      res.value    = '0;
      res.position = '0;
      res.tag      = tag_ff;
      res.status   = status_ff;
      if (status_ff == orq_pkg::STATUS_OK) begin
         res.value    = DW'(value_rdata);
         res.position = PW'(root_ff);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               tag_in  = req_tag;
               vnew_in = req_value[SW-1:0];
               left_in = left_idx;
               cur_in  = left_idx;
               if (req_op == orq_pkg::OP_PUSH) begin
                  if (full) begin
                     status_in = orq_pkg::STATUS_FULL;
                     state_in  = S_RESP;
                  end else if (depth_ff == '0) begin
                     state_in = S_WRITE;
                  end else begin
                     state_in = S_POP_IDX;
                  end
               end else begin
                  if (bad_left) begin
                     status_in = orq_pkg::STATUS_BAD_LEFT;
                     state_in  = S_RESP;
                  end else begin
                     status_in = orq_pkg::STATUS_OK;
                     state_in  = S_FIND;
                  end
               end
            end
         end
         S_POP_IDX: begin
            top_in   = stack_rdata;
            state_in = S_POP_CMP;
         end
         S_POP_CMP: begin
            if (top_greater) begin
               we.parent_we = 1'b1;
               depth_in     = depth_m1;
               state_in     = (depth_ff == CW'(1)) ? S_WRITE : S_POP_IDX;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            we.value_we  = 1'b1;
            we.parent_we = 1'b1;
            we.stack_we  = 1'b1;
            depth_in     = depth_ff + CW'(1);
            count_in     = count_ff + CW'(1);
            state_in     = S_IDLE;
         end
         S_FIND: begin
            if (at_root) begin
               root_in = cur_ff;
               if (left_ff == cur_ff) begin
                  state_in = S_RESP;
               end else begin
                  cur_in   = left_ff;
                  state_in = S_COMP;
               end
            end else begin
               cur_in = parent_rdata;
            end
         end
         S_COMP: begin
            // point this node straight at the root, then advance
            we.parent_we = 1'b1;
            cur_in       = parent_rdata;
            if (parent_rdata == root_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (res_ready) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         depth_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      vnew_ff   <= vnew_in;
      tag_ff    <= tag_in;
      status_ff <= status_in;
      left_ff   <= left_in;
      cur_ff    <= cur_in;
      root_ff   <= root_in;
      top_ff    <= top_in;
   end

endmodule
`default_nettype wire
